>>> rtl/core/heading_rate_stabilizer_macros.svh
// assertion helpers for the heading rate stabilizer
// both expect clk and arst_n in scope
`ifndef HEADING_RATE_STABILIZER_MACROS_SVH
`define HEADING_RATE_STABILIZER_MACROS_SVH

// same-cycle implication
`define HRS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/hrs_pkg.sv
`timescale 1ns / 1ps
package hrs_pkg;

	localparam int RATE_W  = 16;
	localparam int ANGLE_W = 14;
	localparam int LIMIT_W = 15;
	localparam int GAIN_W  = 16;
	localparam int HOLD_W  = 16;

	// q4.11 angle constants
	localparam logic signed [15:0] PI_Q     = 16'sd6434;
	localparam logic signed [15:0] TWO_PI_Q = 16'sd12868;

	// register map, index = paddr[4:2]
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_RATE_LIMIT   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DEADBAND     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HEADING_GAIN = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DAMPING_GAIN = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HOLD_PERIODS = 3'd4;

	localparam logic [LIMIT_W-1:0] RATE_LIMIT_RST   = 15'd12868;
	localparam logic [LIMIT_W-1:0] DEADBAND_RST     = 15'd179;
	localparam logic [GAIN_W-1:0]  HEADING_GAIN_RST = 16'd896;
	localparam logic [GAIN_W-1:0]  DAMPING_GAIN_RST = 16'd26;
	localparam logic [HOLD_W-1:0]  HOLD_PERIODS_RST = 16'd150;

	// magnitude of a signed rate, one bit wider so that -32768 fits
	function automatic logic [RATE_W:0] rate_mag(input logic signed [RATE_W-1:0] v);
		logic signed [RATE_W:0] e;
		e = {v[RATE_W-1], v};
		return e[RATE_W] ? (RATE_W+1)'(-e) : (RATE_W+1)'(e);
	endfunction

endpackage

>>> rtl/core/heading_rate_stabilizer.sv
`timescale 1ns / 1ps
// heading rate stabilizer: one stabilized yaw rate per request
// path to m_tvalid: active request through S_ERR, S_MUL, S_ACC, S_UPD, S_MUL, S_ACC, S_DONE; inactive S_ERR, S_DONE
// s_tready is high only in S_IDLE, so a new request waits until the last one has left S_DONE
// the shared multiply / round / clamp unit runs twice per active request, not when inactive
// a result waiting on m_tready holds the sequencer in its last state, S_DONE, until the output register is free
// reset: arst_n clears the sequencer, output valid and history; registers take defaults
`include "heading_rate_stabilizer_macros.svh"
module heading_rate_stabilizer import hrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input request
	input  logic        s_tvalid,
	output logic        s_tready,
	// command_rate[15:0], robot_yaw[29:16], target_heading[43:30], measured_rate[59:44], zero pad
	input  logic [63:0] s_tdata,
	// absolute_heading_on[0], resist_on[1]
	input  logic [1:0]  s_tuser,
	// result
	output logic        m_tvalid,
	input  logic        m_tready,
	// output_rate[15:0]
	output logic [15:0] m_tdata,
	// was_active[0], damping_applied[1]
	output logic [1:0]  m_tuser,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// sequencer codes
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ERR  = 3'd1; // heading error wrap and activity test
	localparam logic [2:0] S_MUL  = 3'd2; // shared multiplier
	localparam logic [2:0] S_ACC  = 3'd3; // round, add, clamp
	localparam logic [2:0] S_UPD  = 3'd4; // hold counter and damping decision
	localparam logic [2:0] S_DONE = 3'd5; // load output register

	localparam int OPA_W  = 18;
	localparam int PROD_W = 35;
	localparam int SCL_W  = PROD_W - 8;
	localparam int SUM_W  = SCL_W + 1;

	// configuration registers
	logic [LIMIT_W-1:0] rate_limit_q;
	logic [LIMIT_W-1:0] deadband_q;
	logic [GAIN_W-1:0]  heading_gain_q;
	logic [GAIN_W-1:0]  damping_gain_q;
	logic [HOLD_W-1:0]  hold_periods_q;

	// sequencer and request
	logic [2:0]                state_q;
	logic                      pass_q;   // 0: heading pass, 1: damping pass
	logic signed [RATE_W-1:0]  cmd_q;
	logic signed [ANGLE_W-1:0] yaw_q;
	logic signed [ANGLE_W-1:0] tgt_q;
	logic signed [RATE_W-1:0]  meas_q;
	logic                      abs_on_q;
	logic                      resist_q;

	// working values
	logic signed [ANGLE_W-1:0] err_q;
	logic signed [OPA_W-1:0]   diff_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [RATE_W-1:0]  t_q;
	logic                      active_q;
	logic                      damp_q;

	// history
	logic signed [RATE_W-1:0]  prev_q;
	logic [HOLD_W-1:0]         hold_q;
	logic                      first_q;

	// output register
	logic                      out_valid_q;
	logic [RATE_W-1:0]         out_rate_q;
	logic                      out_active_q;
	logic                      out_damp_q;

	logic                      cfg_wr;
	logic [REG_IDX_W-1:0]      cfg_idx;
	logic                      in_acc;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[4:2];
	assign in_acc  = s_tvalid & s_tready;
	assign s_tready = (state_q == S_IDLE);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_rate_q;
	assign m_tuser  = {out_damp_q, out_active_q};

	// register read
	always_comb begin
		unique case (cfg_idx)
			REG_RATE_LIMIT:   prdata = {17'd0, rate_limit_q};
			REG_DEADBAND:     prdata = {17'd0, deadband_q};
			REG_HEADING_GAIN: prdata = {16'd0, heading_gain_q};
			REG_DAMPING_GAIN: prdata = {16'd0, damping_gain_q};
			REG_HOLD_PERIODS: prdata = {16'd0, hold_periods_q};
			default:          prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_limit_q   <= RATE_LIMIT_RST;
			deadband_q     <= DEADBAND_RST;
			heading_gain_q <= HEADING_GAIN_RST;
			damping_gain_q <= DAMPING_GAIN_RST;
			hold_periods_q <= HOLD_PERIODS_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_RATE_LIMIT:   rate_limit_q   <= pwdata[LIMIT_W-1:0];
				REG_DEADBAND:     deadband_q     <= pwdata[LIMIT_W-1:0];
				REG_HEADING_GAIN: heading_gain_q <= pwdata[GAIN_W-1:0];
				REG_DAMPING_GAIN: damping_gain_q <= pwdata[GAIN_W-1:0];
				REG_HOLD_PERIODS: hold_periods_q <= pwdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// heading error, wrapped once by 2*pi
	logic signed [ANGLE_W:0] raw_err;
	logic signed [15:0]      raw_err_x;
	logic signed [15:0]      wrap_err;
	logic                    active_now;

	always_comb begin
		raw_err   = {tgt_q[ANGLE_W-1], tgt_q} - {yaw_q[ANGLE_W-1], yaw_q};
		raw_err_x = {raw_err[ANGLE_W], raw_err};
		if (raw_err_x > PI_Q)
			wrap_err = raw_err_x - TWO_PI_Q;
		else if (raw_err_x < -PI_Q)
			wrap_err = raw_err_x + TWO_PI_Q;
		else
			wrap_err = raw_err_x;
		active_now = (rate_mag(cmd_q) > {2'b00, deadband_q}) | abs_on_q;
	end

	// shared unit: multiplier operands
	logic signed [OPA_W-1:0]    op_a;
	logic signed [GAIN_W:0]     op_b;
	logic signed [PROD_W-1:0]   prod;

	always_comb begin
		if (pass_q) begin
			op_a = diff_q;
			op_b = {1'b0, damping_gain_q};
		end else begin
			op_a = abs_on_q ? {{(OPA_W-ANGLE_W){err_q[ANGLE_W-1]}}, err_q} : '0;
			op_b = {1'b0, heading_gain_q};
		end
		prod = PROD_W'(op_a * op_b);
	end

	// shared unit: round to nearest (ties up), add to base, clamp to the limit
	logic signed [PROD_W-1:0] rnd;
	logic signed [SCL_W-1:0]  scaled;
	logic signed [RATE_W-1:0] base;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  lim;
	logic signed [RATE_W-1:0] clamped;

	always_comb begin
		rnd    = prod_q + PROD_W'(128);
		scaled = rnd[PROD_W-1:8];
		base   = pass_q ? t_q : cmd_q;
		sum    = {{(SUM_W-RATE_W){base[RATE_W-1]}}, base} + {scaled[SCL_W-1], scaled};
		lim    = {{(SUM_W-LIMIT_W){1'b0}}, rate_limit_q};
		if (sum > lim)
			clamped = lim[RATE_W-1:0];
		else if (sum < -lim)
			clamped = RATE_W'(-lim);
		else
			clamped = sum[RATE_W-1:0];
	end

	// hold counter and damping decision
	logic              reload;
	logic [HOLD_W-1:0] hold_next;
	logic              damp_now;

	always_comb begin
		reload    = !first_q || (rate_mag(t_q) < rate_mag(prev_q))
		            || (t_q == '0 && prev_q != '0);
		hold_next = reload ? hold_periods_q : hold_q;
		damp_now  = resist_q && (hold_next == '0) && (rate_mag(t_q) < rate_mag(meas_q));
	end

	// request capture, working values and output rate, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q    <= s_tdata[15:0];
			yaw_q    <= s_tdata[29:16];
			tgt_q    <= s_tdata[43:30];
			meas_q   <= s_tdata[59:44];
			abs_on_q <= s_tuser[0];
			resist_q <= s_tuser[1];
		end
		if (state_q == S_ERR)
			err_q <= wrap_err[ANGLE_W-1:0];
		if (state_q == S_MUL)
			prod_q <= prod;
		if (state_q == S_UPD)
			diff_q <= damp_now
				? ({{(OPA_W-RATE_W){t_q[RATE_W-1]}}, t_q}
				   - {{(OPA_W-RATE_W){meas_q[RATE_W-1]}}, meas_q})
				: '0;
		if (state_q == S_ERR && !active_now)
			t_q <= cmd_q;
		else if (state_q == S_ACC)
			t_q <= clamped;
		if (state_q == S_DONE && (!out_valid_q || m_tready))
			out_rate_q <= t_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pass_q       <= 1'b0;
			active_q     <= 1'b0;
			damp_q       <= 1'b0;
			prev_q       <= '0;
			hold_q       <= '0;
			first_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_active_q <= 1'b0;
			out_damp_q   <= 1'b0;
		end else begin
			// output register loads when free or drained this cycle
			if (state_q == S_DONE && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_ERR;
						pass_q  <= 1'b0;
					end
				end
				S_ERR: begin
					active_q <= active_now;
					damp_q   <= 1'b0;
					if (active_now) begin
						state_q <= S_MUL;
					end else begin
						// pass-through period still counts down the hold
						if (hold_q != '0)
							hold_q <= hold_q - HOLD_W'(1);
						state_q <= S_DONE;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					state_q <= pass_q ? S_DONE : S_UPD;
				end
				S_UPD: begin
					first_q <= 1'b1;
					prev_q  <= t_q;
					hold_q  <= (hold_next != '0) ? hold_next - HOLD_W'(1) : '0;
					damp_q  <= damp_now;
					pass_q  <= 1'b1;
					state_q <= S_MUL;
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_active_q <= active_q;
						out_damp_q   <= damp_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	logic [RATE_W:0] out_mag;
	assign out_mag = rate_mag(out_rate_q);

	`HRS_ASSERT_IMP(a_damp_needs_active, out_valid_q && out_damp_q, out_active_q,
		"damping flagged on an inactive result")
	`HRS_ASSERT_NEXT(a_accept_starts_seq, in_acc, state_q == S_ERR,
		"accepted request did not start the sequencer")
	`HRS_ASSERT_IMP(a_active_within_limit, out_valid_q && out_active_q,
		out_mag <= {2'b00, rate_limit_q}, "active result exceeds the rate limit")

endmodule

>>> tb/sv/heading_rate_checker.sv
`timescale 1ns / 1ps
module heading_rate_checker import hrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// command_rate[15:0], robot_yaw[29:16], target_heading[43:30], measured_rate[59:44], zero pad
	input  logic [63:0] s_tdata,
	// absolute_heading_on[0], resist_on[1]
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// output_rate[15:0]
	input  logic [15:0] m_tdata,
	// was_active[0], damping_applied[1]
	input  logic [1:0]  m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output int          pending,
	output int          failures,
	output int          checked,
	output int          active_seen,
	output int          damped_seen
);

	typedef struct packed {
		logic [RATE_W-1:0]  command_rate;
		logic [ANGLE_W-1:0] robot_yaw;
		logic [ANGLE_W-1:0] target_heading;
		logic [RATE_W-1:0]  measured_rate;
		logic               absolute_heading_on;
		logic               resist_on;
	} yaw_request_t;

	typedef struct packed {
		logic [RATE_W-1:0] output_rate;
		logic              was_active;
		logic              damping_applied;
	} yaw_result_t;

	// register copies
	logic [LIMIT_W-1:0] limit_q;
	logic [LIMIT_W-1:0] deadband_q;
	logic [GAIN_W-1:0]  hgain_q;
	logic [GAIN_W-1:0]  dgain_q;
	logic [HOLD_W-1:0]  hold_q;

	// history of the stabilizer
	logic signed [RATE_W-1:0] last_rate;
	logic [HOLD_W-1:0]        hold_left;
	logic                     seen_active;

	yaw_result_t expected_rates[$];
	yaw_request_t req;
	yaw_result_t want;
	int fail_total;
	int checked_total;
	int active_total;
	int damped_total;

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// q12.19 product back to q4.11, round half up
	function automatic longint scale_gain(input longint p);
		return (p + 128) >>> 8;
	endfunction

	function automatic longint limit_rate(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic yaw_result_t stabilize_rate(input yaw_request_t r);
		yaw_result_t res;
		longint cmd, yaw, tgt, meas, err, rate, lim, db, hgain, dgain;
		logic reload;
		cmd   = $signed(r.command_rate);
		yaw   = $signed(r.robot_yaw);
		tgt   = $signed(r.target_heading);
		meas  = $signed(r.measured_rate);
		lim   = {49'd0, limit_q};
		db    = {49'd0, deadband_q};
		hgain = {48'd0, hgain_q};
		dgain = {48'd0, dgain_q};
		rate  = cmd;
		res.was_active      = 1'b0;
		res.damping_applied = 1'b0;
		if (magnitude(cmd) > db || r.absolute_heading_on) begin
			if (r.absolute_heading_on) begin
				err = tgt - yaw;
				if (err > longint'(PI_Q))
					err -= longint'(TWO_PI_Q);
				else if (err < -longint'(PI_Q))
					err += longint'(TWO_PI_Q);
				rate += scale_gain(err * hgain);
			end
			rate = limit_rate(rate, lim);
			if (!seen_active) begin
				seen_active = 1'b1;
				reload = 1'b1;
			end else begin
				reload = magnitude(rate) < magnitude(last_rate) ||
					(rate == 0 && last_rate != 0);
			end
			if (reload)
				hold_left = hold_q;
			last_rate = 16'(rate);
			if (r.resist_on && hold_left == 0 && magnitude(rate) < magnitude(meas)) begin
				rate += scale_gain((rate - meas) * dgain);
				res.damping_applied = 1'b1;
			end
			rate = limit_rate(rate, lim);
			res.was_active = 1'b1;
		end
		if (hold_left != 0)
			hold_left--;
		res.output_rate = 16'(rate);
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		fail_total++;
		$display("[%0t] stabilizer check failed: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q       = RATE_LIMIT_RST;
			deadband_q    = DEADBAND_RST;
			hgain_q       = HEADING_GAIN_RST;
			dgain_q       = DAMPING_GAIN_RST;
			hold_q        = HOLD_PERIODS_RST;
			last_rate     = '0;
			hold_left     = '0;
			seen_active   = 1'b0;
			fail_total    = 0;
			checked_total = 0;
			active_total  = 0;
			damped_total  = 0;
			expected_rates.delete();
			pending     <= 0;
			failures    <= 0;
			checked     <= 0;
			active_seen <= 0;
			damped_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				checked_total++;
				if (expected_rates.size() == 0) begin
					report_mismatch($sformatf("result %0d with no request outstanding",
						checked_total));
				end else begin
					want = expected_rates.pop_front();
					if (m_tdata !== want.output_rate)
						report_mismatch($sformatf("result %0d output_rate %0d, want %0d",
							checked_total, $signed(m_tdata), $signed(want.output_rate)));
					if (m_tuser[0] !== want.was_active)
						report_mismatch($sformatf("result %0d was_active %b, want %b",
							checked_total, m_tuser[0], want.was_active));
					if (m_tuser[1] !== want.damping_applied)
						report_mismatch($sformatf("result %0d damping_applied %b, want %b",
							checked_total, m_tuser[1], want.damping_applied));
					if (want.was_active)
						active_total++;
					if (want.damping_applied)
						damped_total++;
				end
			end
			if (s_tvalid && s_tready) begin
				req.command_rate        = s_tdata[15:0];
				req.robot_yaw           = s_tdata[29:16];
				req.target_heading      = s_tdata[43:30];
				req.measured_rate       = s_tdata[59:44];
				req.absolute_heading_on = s_tuser[0];
				req.resist_on           = s_tuser[1];
				expected_rates.push_back(stabilize_rate(req));
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_RATE_LIMIT:   limit_q    = pwdata[LIMIT_W-1:0];
					REG_DEADBAND:     deadband_q = pwdata[LIMIT_W-1:0];
					REG_HEADING_GAIN: hgain_q    = pwdata[GAIN_W-1:0];
					REG_DAMPING_GAIN: dgain_q    = pwdata[GAIN_W-1:0];
					REG_HOLD_PERIODS: hold_q     = pwdata[HOLD_W-1:0];
					default: ;
				endcase
			end
			pending     <= expected_rates.size();
			failures    <= fail_total;
			checked     <= checked_total;
			active_seen <= active_total;
			damped_seen <= damped_total;
		end
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import hrs_pkg::*;

	// cycles with no request or result accepted before the run is declared hung
	localparam int STALL_LIMIT   = 2000;
	// random requests per register setting, nine settings in all
	localparam int SEGMENT_ITEMS = 195;
	localparam int SEGMENTS      = 9;
	// leave room after the last result for a stray result to show up
	localparam int TAIL_CYCLES   = 16;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// command_rate[15:0], robot_yaw[29:16], target_heading[43:30], measured_rate[59:44], zero pad
	logic [63:0] s_tdata = '0;
	// absolute_heading_on[0], resist_on[1]
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// output_rate[15:0]
	logic [15:0] m_tdata;
	// was_active[0], damping_applied[1]
	logic [1:0]  m_tuser;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [4:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	// scoreboard outputs
	int pending;
	int failures;
	int checked;
	int active_seen;
	int damped_seen;

	// stimulus bookkeeping
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int deadband_now  = DEADBAND_RST;
	int ramp_rate     = 0;
	int stall_cycles  = 0;
	int requests_sent = 0;
	int directed_sent = 0;
	int settings_used = 0;

	always #1 clk = ~clk;

	heading_rate_stabilizer uut (.*);

	heading_rate_checker scoreboard (.*);

	// result side back-pressure, one draw per cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog: any accepted request or result restarts the count
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("no traffic for %0d cycles, %0d results outstanding", STALL_LIMIT, pending);
			$display("heading_rate_stabilizer regression: fail");
			$finish;
		end
	end

	function automatic int fit_rate(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// valid stays high between back-to-back requests, it only drops while idling
	task automatic send_request(input int cmd, input int yaw, input int tgt, input int meas,
			input logic abs_on, input logic resist);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, 16'(meas), 14'(tgt), 14'(yaw), 16'(cmd)};
		s_tuser  <= {resist, abs_on};
		do @(posedge clk); while (!s_tready);
		requests_sent++;
	endtask

	// hold the sender off until every outstanding result is back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// setup cycle then access cycle, psel stays up between back-to-back writes
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// registers only change with the pipeline empty
	task automatic apply_setting(input int rl, input int db, input int hg, input int dg,
			input int hp);
		wait_for_results();
		write_reg(REG_RATE_LIMIT, rl);
		write_reg(REG_DEADBAND, db);
		write_reg(REG_HEADING_GAIN, hg);
		write_reg(REG_DAMPING_GAIN, dg);
		write_reg(REG_HOLD_PERIODS, hp);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		deadband_now = db;
		settings_used++;
	endtask

	task automatic send_random_request();
		int cmd, meas, yaw, tgt, span;
		logic abs_on, resist;
		case ($urandom_range(9))
			// rate ramping away from zero: no drop, so the hold runs out and damping kicks in
			0, 1, 2: begin
				span = $urandom_range(300);
				cmd = fit_rate((ramp_rate < 0) ? ramp_rate - span : ramp_rate + span);
				if (cmd == 32767 || cmd == -32768)
					cmd = int'($urandom_range(400)) - 200;
			end
			// around the deadband edges
			3, 4: cmd = fit_rate(int'($urandom_range(2 * deadband_now + 200)) - deadband_now - 100);
			5, 6: cmd = int'($signed(16'($urandom)));
			7: begin
				case ($urandom_range(4))
					0: cmd = 32767;
					1: cmd = -32768;
					2: cmd = 0;
					3: cmd = 1;
					default: cmd = -1;
				endcase
			end
			default: cmd = int'($urandom_range(8000)) - 4000;
		endcase
		ramp_rate = cmd;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: meas = int'($signed(16'($urandom)));
			5, 6, 7: meas = fit_rate(cmd + int'($urandom_range(4000)) - 2000);
			8: meas = 32767;
			default: meas = -32768;
		endcase
		// angles span the full plus minus pi, pinned to the ends now and then
		if ($urandom_range(9) == 0)
			yaw = ($urandom_range(1) != 0) ? 6434 : -6434;
		else
			yaw = int'($urandom_range(12868)) - 6434;
		if ($urandom_range(9) == 0)
			tgt = ($urandom_range(1) != 0) ? 6434 : -6434;
		else
			tgt = int'($urandom_range(12868)) - 6434;
		abs_on = ($urandom_range(99) < 35);
		resist = ($urandom_range(99) < 80);
		send_request(cmd, yaw, tgt, meas, abs_on, resist);
	endtask

	initial begin
		int seg;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: deadband edges, clamps and heading wrap
		send_request(0, 0, 0, 0, 1'b0, 1'b0);
		send_request(179, 0, 0, 0, 1'b0, 1'b1);
		send_request(-179, 0, 0, 0, 1'b0, 1'b1);
		// first active period loads the hold
		send_request(180, 0, 0, 1000, 1'b0, 1'b1);
		send_request(32767, 0, 0, -32768, 1'b0, 1'b1);
		send_request(-32768, 0, 0, 32767, 1'b0, 1'b1);
		// heading error of two pi wraps to zero, rate falls to zero
		send_request(0, -6434, 6434, 0, 1'b1, 1'b0);
		send_request(500, 6434, -6434, 0, 1'b1, 1'b1);
		// exactly pi stays, one past pi wraps around
		send_request(0, 0, 6434, 0, 1'b1, 1'b0);
		send_request(0, -1, 6434, 0, 1'b1, 1'b0);
		send_request(0, 6434, 0, 0, 1'b1, 1'b0);

		// widest limit, no deadband, zero gains, no hold
		apply_setting(32767, 0, 0, 0, 0);
		// zero damping gain still flags damping
		send_request(1000, 0, 0, 32767, 1'b0, 1'b1);
		send_request(-32768, 0, 0, -32768, 1'b0, 1'b1);
		send_request(1, 0, 0, 32767, 1'b0, 1'b0);

		// full damping gain and a two period hold
		apply_setting(32767, 0, 0, 65535, 2);
		send_request(100, 0, 0, -32768, 1'b0, 1'b1);
		send_request(50, 0, 0, 30000, 1'b0, 1'b1);
		send_request(60, 0, 0, 30000, 1'b0, 1'b1);
		send_request(70, 0, 0, 30000, 1'b0, 1'b1);

		// zero rate limit with full heading gain
		apply_setting(0, 0, 65535, 65535, 2);
		send_request(300, -6434, 0, 1000, 1'b1, 1'b1);
		send_request(0, 0, 0, 1000, 1'b0, 1'b1);

		// largest deadband: only -32768 gets past it
		apply_setting(32767, 32767, 896, 26, 0);
		send_request(-32768, 0, 0, 0, 1'b0, 1'b1);
		send_request(32767, 0, 0, 0, 1'b0, 1'b1);
		directed_sent = requests_sent;

		// random part: sender idles less than receiver, then the reverse, then no idling
		for (seg = 0; seg < SEGMENTS; seg++) begin
			if (seg == 0) begin
				send_idle_pct = 23;
				recv_idle_pct <= 57;
			end else if (seg == 3) begin
				send_idle_pct = 57;
				recv_idle_pct <= 23;
			end else if (seg == 6) begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			case (seg)
				0: apply_setting(RATE_LIMIT_RST, DEADBAND_RST, HEADING_GAIN_RST,
					DAMPING_GAIN_RST, HOLD_PERIODS_RST);
				1: apply_setting(32767, 0, 65535, 65535, 0);
				3: apply_setting(0, 32767, 0, 0, 65535);
				default: apply_setting($urandom_range(1000, 20000), $urandom_range(600),
					$urandom_range(2048), $urandom_range(512), $urandom_range(4));
			endcase
			repeat (SEGMENT_ITEMS) send_random_request();
		end

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d requests (%0d directed) over %0d register settings and three idle patterns",
			requests_sent, directed_sent, settings_used + 1);
		$display("checked %0d results: %0d on the stabilizing path, %0d with rate damping",
			checked, active_seen, damped_seen);
		if (failures == 0 && pending == 0)
			$display("heading_rate_stabilizer regression: pass");
		else
			$display("heading_rate_stabilizer regression: fail");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/hrs_pkg.sv
rtl/core/heading_rate_stabilizer.sv
tb/sv/heading_rate_checker.sv
tb/sv/tb.sv
